FILE: rtl/btda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package btda_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int BCD_W               = 4;
  localparam int CHAR_W              = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Per-cycle control broadcast along the digit chain
  typedef struct packed {
    logic clear;    // zero every digit
    logic dabble;   // correct and shift one binary bit in
    logic advance;  // move every digit one place towards the top
  } cell_ctl_t;

endpackage

FILE: rtl/btda_cell.sv
// One BCD digit cell of the shift-and-add-3 conversion chain.
module btda_cell (
  input  logic                     clk,
  input  btda_pkg::cell_ctl_t      ctl,
  input  logic                     bit_in,
  output logic                     bit_out,
  input  logic [btda_pkg::BCD_W-1:0] digit_in,
  output logic [btda_pkg::BCD_W-1:0] digit
);
  import btda_pkg::*;

  logic [BCD_W-1:0] corrected;

  // Add three before the shift so that a digit of five or more carries out
  assign corrected = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign bit_out   = corrected[BCD_W-1];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.dabble) begin
      digit <= {corrected[BCD_W-2:0], bit_in};
    end else if (ctl.advance) begin
      digit <= digit_in;
    end
  end

endmodule

FILE: rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter: one transaction in, one to NUM_DIGITS digits out.
// Operation: the value is shifted into a chain of BCD cells one bit a cycle, then leading
// zeros are dropped one a cycle (up to NUM_DIGITS-1), then one digit leaves each cycle the
// output is not stalled. A new number is taken only in idle, once the last digit of the
// previous number has been taken into the output register; in_stall is high until then.
// Reset (rst, synchronous) returns the control to idle and empties the output register.
module binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = btda_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [VALUE_WIDTH-1:0]       number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [btda_pkg::CHAR_W-1:0]  digit_char,
  output logic                         last_digit
);
  import btda_pkg::*;

  // Digits needed for 2^VALUE_WIDTH - 1: floor(VALUE_WIDTH * log10(2)) + 1
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCNT_W     = $clog2(VALUE_WIDTH + 1);
  localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                   state, state_next;
  logic [VALUE_WIDTH-1:0]   shreg;
  logic [BCNT_W-1:0]        bit_cnt;
  logic [DCNT_W-1:0]        dig_cnt;
  logic                     started;
  cell_ctl_t                ctl;
  logic [NUM_DIGITS:0]      carry;
  logic [BCD_W-1:0]         dchain [0:NUM_DIGITS];
  logic [BCD_W-1:0]         top_digit;
  logic                     accept, skip, take;

  assign carry[0]  = shreg[VALUE_WIDTH-1];
  assign dchain[0] = '0;
  assign top_digit = dchain[NUM_DIGITS];

  genvar gi;
  generate
    for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
      btda_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .bit_in   (carry[gi]),
        .bit_out  (carry[gi+1]),
        .digit_in (dchain[gi]),
        .digit    (dchain[gi+1])
      );
    end
  endgenerate

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next  = state;
    skip        = 1'b0;
    take        = 1'b0;
    ctl.clear   = 1'b0;
    ctl.dabble  = 1'b0;
    ctl.advance = 1'b0;
    unique case (state)
      S_IDLE: begin
        ctl.clear = accept;
        if (accept) state_next = S_CONV;
      end
      S_CONV: begin
        ctl.dabble = 1'b1;
        if (bit_cnt == BCNT_W'(1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        // Drop leading zeros, but always keep the units digit
        skip        = !started && (top_digit == '0) && (dig_cnt != DCNT_W'(1));
        take        = !skip && (!out_valid || !out_stall);
        ctl.advance = skip || take;
        if (take && dig_cnt == DCNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        started <= 1'b0;
      end else if (take) begin
        started <= 1'b1;
      end
    end
  end

  // Payload and counters
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg   <= number;
      bit_cnt <= BCNT_W'(VALUE_WIDTH);
      dig_cnt <= DCNT_W'(NUM_DIGITS);
    end else if (ctl.dabble) begin
      shreg   <= {shreg[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt - BCNT_W'(1);
    end else if (ctl.advance) begin
      dig_cnt <= dig_cnt - DCNT_W'(1);
    end
    if (take) begin
      digit_char <= ASCII_ZERO + {{(CHAR_W-BCD_W){1'b0}}, top_digit};
      last_digit <= (dig_cnt == DCNT_W'(1));
    end
  end

endmodule

FILE: sim/binary_to_decimal_ascii_tb.sv
// Testbench for the binary to decimal ASCII converter: directed and random stimulus, digit scoreboard.
`timescale 1ns / 1ps

class digit_scoreboard;
  typedef struct packed {
    logic [btda_pkg::CHAR_W-1:0] digit_char;
    logic                        last_digit;
  } digit_t;

  digit_t pending_digits[$];
  int     errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return pending_digits.size();
  endfunction

  // Split the value into decimal digits and queue them most significant first.
  function void note_number(logic [31:0] value);
    logic [3:0]  lsd_first[10];
    logic [31:0] rest;
    int          count;
    digit_t      d;
    rest  = value;
    count = 0;
    do begin
      lsd_first[count] = 4'(rest % 32'd10);
      rest             = rest / 32'd10;
      count++;
    end while (rest != 32'd0);
    for (int k = count - 1; k >= 0; k--) begin
      d.digit_char = btda_pkg::ASCII_ZERO + btda_pkg::CHAR_W'(lsd_first[k]);
      d.last_digit = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  function void check_digit(logic [btda_pkg::CHAR_W-1:0] digit_char, logic last_digit);
    digit_t want;
    if (pending_digits.size() == 0) begin
      $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
               $time, digit_char, last_digit);
      errors++;
      return;
    end
    want = pending_digits.pop_front();
    if (digit_char !== want.digit_char) begin
      $display("%0t: digit_char mismatch: expected %0d, actual %0d",
               $time, want.digit_char, digit_char);
      errors++;
    end
    if (last_digit !== want.last_digit) begin
      $display("%0t: last_digit mismatch: expected %0b, actual %0b",
               $time, want.last_digit, last_digit);
      errors++;
    end
  endfunction
endclass

module binary_to_decimal_ascii_tb;

  localparam int NUM_RANDOM = 400;
  localparam int NUM_QUIET  = 60;
  localparam int DRAIN      = 64;

  logic                        clk        = 1'b0;
  logic                        rst        = 1'b1;
  logic                        in_valid   = 1'b0;
  logic                        in_stall;
  logic [31:0]                 number     = '0;
  logic                        out_valid;
  logic                        out_stall  = 1'b0;
  logic [btda_pkg::CHAR_W-1:0] digit_char;
  logic                        last_digit;

  logic        quiet     = 1'b0;
  int          gap_odds  = 4;
  logic [31:0] pow10[10] = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
                             32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};

  digit_scoreboard sb;

  binary_to_decimal_ascii dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit_char(digit_char),
    .last_digit(last_digit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Observe both channels on the edge that completes each transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_number(number);
      end
      if (out_valid && !out_stall) begin
        sb.check_digit(digit_char, last_digit);
      end
    end
  end

  // Receiver back-pressure in random bursts; release for good once quiet.
  initial begin
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_number(input logic [31:0] value);
    in_valid <= 1'b1;
    number   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_number();
    int k;
    k = $urandom_range(0, 9);
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return (k == 0) ? 32'd0 : $urandom % pow10[k];
      3:       return $urandom_range(0, 1) ? pow10[k] : pow10[k] - 32'd1;
      4:       return $urandom_range(0, 99);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  initial begin
    logic [31:0] directed[$];
    sb = new();
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                 32'd12345, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
                 32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
                 32'd999999999, 32'd1000000000, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i]);
    // Hold the sender until the converter has fully drained.
    wait_for_drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_odds = 0;
          1:       gap_odds = 2;
          default: gap_odds = 4;
        endcase
      end
      if (i == NUM_RANDOM - NUM_QUIET) begin
        quiet = 1'b1;
      end
      if (i == NUM_RANDOM / 2) begin
        wait_for_drain();
      end
      send_number(random_number());
    end
    wait_for_drain();

    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d digits outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
